[hw/rtl/vht_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vht_pkg
// Shared types and constants of the versioned handle table.
// ----------------------------------------------------------------------------
package vht_pkg;

    localparam int MAX_SLOTS_DEF = 1024;

    localparam int CMD_W    = 2;
    localparam int HANDLE_W = 32;
    localparam int PTR_W    = 64;
    localparam int TAG_W    = 32;
    localparam int VER_W    = 16;
    localparam int HIDX_W   = 16;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_FREE   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_STALE = 2'd3
    } status_t;

    // free stack control from the sequencer
    typedef struct packed {
        logic              rd;
        logic              pop;
        logic              push;
        logic [HIDX_W-1:0] push_idx;
    } stk_req_t;

endpackage
`default_nettype wire

[hw/rtl/versioned_handle_table_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// versioned_handle_table_core
// Generational handle table: slot memory {version, pointer, tag} plus a
// free-index stack; allocate, lookup, check and free requests.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                       | tuser
//  s_      | in  | handle_in, pointer_value, type_tag       | command
//  m_      | out | handle_out, pointer_out, is_valid, status | -
//
//  Allocate: stack read (S_IDLE), slot read (S_POP), write-back (S_RMW);
//  other requests: slot read (S_IDLE), write-back (S_RMW); a full table or
//  an out-of-range handle skips the slot read. One request in flight.
//  After reset both memories are swept, s_tready low.
//  A request is accepted while a result waits in the output register; the
//  write-back stalls until that register is free.
// ----------------------------------------------------------------------------
module versioned_handle_table_core
    import vht_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // handle_in, pointer_value, type_tag
    input  wire logic [1:0]   s_tuser,   // command
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata    // handle_out, pointer_out, is_valid, status
);

    localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int SLOT_W = VER_W + PTR_W + TAG_W;
    localparam logic [HIDX_W:0] MAX_EXT = (HIDX_W + 1)'(MAX_SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_RMW
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic                full_reg, full_next;
    logic                range_reg, range_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;

    logic                m_valid_reg, m_valid_next;
    logic [HANDLE_W-1:0] o_handle_reg, o_handle_next;
    logic [PTR_W-1:0]    o_ptr_reg, o_ptr_next;
    logic                o_valid_reg, o_valid_next;
    status_t             o_status_reg, o_status_next;

    logic [CNT_W-1:0] clr_reg, clr_next;
    logic             clr_done;

    logic [HANDLE_W-1:0] in_handle;
    logic [PTR_W-1:0]    in_ptr;
    logic [TAG_W-1:0]    in_tag;
    cmd_t                in_cmd;
    logic [HIDX_W-1:0]   in_idx;
    logic                in_range;
    logic                accept;
    logic                out_free;

    stk_req_t         stk_req;
    logic [CNT_W-1:0] stk_count;
    logic [IDX_W-1:0] stk_top;
    logic             stk_done;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [SLOT_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [SLOT_W-1:0] ram_rdata;
    logic              op_we;
    logic [SLOT_W-1:0] op_wdata;

    logic [VER_W-1:0] rd_ver;
    logic [PTR_W-1:0] rd_ptr;
    logic [TAG_W-1:0] rd_tag;
    logic [VER_W-1:0] ver_inc;
    logic             ver_eq;
    logic             match;

    assign in_handle = s_tdata[31:0];
    assign in_ptr    = s_tdata[95:32];
    assign in_tag    = s_tdata[127:96];
    assign in_cmd    = cmd_t'(s_tuser);
    assign in_idx    = in_handle[HANDLE_W-1:VER_W];
    assign in_range  = {1'b0, in_idx} < MAX_EXT;

    assign clr_done = (clr_reg == CNT_W'(MAX_SLOTS));
    assign s_tready = (state_reg == S_IDLE) && clr_done && stk_done;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign {rd_ver, rd_ptr, rd_tag} = ram_rdata;
    assign ver_inc = rd_ver + VER_W'(1);
    assign ver_eq  = (rd_ver == handle_reg[VER_W-1:0]);
    assign match   = ver_eq && (rd_tag == tag_reg);

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        handle_next   = handle_reg;
        ptr_next      = ptr_reg;
        tag_next      = tag_reg;
        full_next     = full_reg;
        range_next    = range_reg;
        slot_next     = slot_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        o_handle_next = o_handle_reg;
        o_ptr_next    = o_ptr_reg;
        o_valid_next  = o_valid_reg;
        o_status_next = o_status_reg;
        clr_next      = clr_done ? clr_reg : clr_reg + CNT_W'(1);
        stk_req       = '0;
        ram_re        = 1'b0;
        ram_raddr     = in_idx[IDX_W-1:0];
        op_we         = 1'b0;
        op_wdata      = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next    = in_cmd;
                    handle_next = in_handle;
                    ptr_next    = in_ptr;
                    tag_next    = in_tag;
                    full_next   = 1'b0;
                    range_next  = 1'b0;
                    slot_next   = in_idx[IDX_W-1:0];
                    if (in_cmd == CMD_ALLOC) begin
                        if (stk_count == '0) begin
                            full_next  = 1'b1;
                            state_next = S_RMW;
                        end else begin
                            stk_req.rd  = 1'b1;
                            stk_req.pop = 1'b1;
                            state_next  = S_POP;
                        end
                    end else if (!in_range) begin
                        range_next = 1'b1;
                        state_next = S_RMW;
                    end else begin
                        ram_re     = 1'b1;
                        state_next = S_RMW;
                    end
                end
            end
            S_POP: begin
                slot_next  = stk_top;
                ram_re     = 1'b1;
                ram_raddr  = stk_top;
                state_next = S_RMW;
            end
            S_RMW: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    o_handle_next = '0;
                    o_ptr_next    = '0;
                    o_valid_next  = 1'b0;
                    o_status_next = ST_OK;
                    state_next    = S_IDLE;
                    if (full_reg) begin
                        o_status_next = ST_FULL;
                    end else if (range_reg) begin
                        o_status_next = ST_RANGE;
                    end else begin
                        case (cmd_reg)
                            CMD_ALLOC: begin
                                op_we         = 1'b1;
                                op_wdata      = {ver_inc, ptr_reg, tag_reg};
                                o_handle_next = {HIDX_W'(slot_reg), ver_inc};
                            end
                            CMD_LOOKUP: begin
                                if (match) begin
                                    o_ptr_next   = rd_ptr;
                                    o_valid_next = 1'b1;
                                end else begin
                                    o_status_next = ST_STALE;
                                end
                            end
                            CMD_CHECK: begin
                                o_valid_next = match;
                            end
                            CMD_FREE: begin
                                if (ver_eq && (stk_count < CNT_W'(MAX_SLOTS))) begin
                                    op_we            = 1'b1;
                                    op_wdata         = {ver_inc, {PTR_W{1'b0}}, rd_tag};
                                    stk_req.push     = 1'b1;
                                    stk_req.push_idx = HIDX_W'(slot_reg);
                                end else begin
                                    o_status_next = ST_STALE;
                                end
                            end
                            default: begin
                                o_status_next = ST_OK;
                            end
                        endcase
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (!clr_done) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg[IDX_W-1:0];
            ram_wdata = '0;
        end else begin
            ram_we    = op_we;
            ram_waddr = slot_reg;
            ram_wdata = op_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            clr_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            clr_reg     <= clr_next;
        end
        cmd_reg      <= cmd_next;
        handle_reg   <= handle_next;
        ptr_reg      <= ptr_next;
        tag_reg      <= tag_next;
        full_reg     <= full_next;
        range_reg    <= range_next;
        slot_reg     <= slot_next;
        o_handle_reg <= o_handle_next;
        o_ptr_reg    <= o_ptr_next;
        o_valid_reg  <= o_valid_next;
        o_status_reg <= o_status_next;
    end

    vht_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    vht_free_stack #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_free_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (stk_req),
        .count     (stk_count),
        .top_idx   (stk_top),
        .init_done (stk_done)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, o_status_reg, o_valid_reg, o_ptr_reg, o_handle_reg};

    a_write_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        op_we |-> (state_reg == S_RMW) && out_free && clr_done)
        else $error("slot write outside write-back");

    a_alloc_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (in_cmd == CMD_ALLOC) && (stk_count != '0)
        |=> (stk_count == $past(stk_count) - CNT_W'(1)))
        else $error("allocate did not pop free stack");

    a_valid_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && o_valid_reg |-> (o_status_reg == ST_OK) && (o_handle_reg == '0))
        else $error("valid result with error status");

    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RMW) && out_free |=> m_valid_reg && (state_reg == S_IDLE))
        else $error("write-back did not load result");

endmodule
`default_nettype wire

[hw/rtl/vht_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vht_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[hw/rtl/vht_free_stack.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vht_free_stack
// LIFO of free slot indices with fill count; fills itself after reset so
// that index 0 is on top.
// ----------------------------------------------------------------------------
module vht_free_stack
    import vht_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire stk_req_t                                   req,
    output logic [$clog2(MAX_SLOTS + 1)-1:0]                count,
    output logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] top_idx,
    output logic                                            init_done
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0] pop_pos;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;

    assign init_done = (clr_reg == CNT_W'(MAX_SLOTS));
    assign pop_pos   = count_reg - CNT_W'(1);

    always_comb begin
        clr_next   = clr_reg;
        count_next = count_reg;
        if (!init_done) begin
            clr_next = clr_reg + CNT_W'(1);
        end
        if (req.pop) begin
            count_next = count_reg - CNT_W'(1);
        end else if (req.push) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb begin
        if (!init_done) begin
            we    = 1'b1;
            waddr = clr_reg[IDX_W-1:0];
            wdata = IDX_W'(MAX_SLOTS - 1) - clr_reg[IDX_W-1:0];
        end else begin
            we    = req.push;
            waddr = count_reg[IDX_W-1:0];
            wdata = req.push_idx[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CNT_W'(MAX_SLOTS);
            clr_reg   <= '0;
        end else begin
            count_reg <= count_next;
            clr_reg   <= clr_next;
        end
    end

    vht_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_SLOTS)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (req.rd),
        .raddr (pop_pos[IDX_W-1:0]),
        .rdata (top_idx)
    );

    assign count = count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_SLOTS))
        else $error("free count above table size");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        req.pop |-> (count_reg != '0) && !req.push)
        else $error("pop on empty stack or with push");

    a_push_nonfull: assert property (@(posedge aclk) disable iff (!aresetn)
        req.push |-> (count_reg < CNT_W'(MAX_SLOTS)) && init_done)
        else $error("push on full stack");

endmodule
`default_nettype wire
